// ----- rtl/bc1_to_bc5_block_decoder_macros.svh -----
// Assertion macros for the BC1 to BC5 block decoder checker.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef BC1_TO_BC5_BLOCK_DECODER_MACROS_SVH
`define BC1_TO_BC5_BLOCK_DECODER_MACROS_SVH

// Property checked at every clock edge outside reset.
`define BC15_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked at every clock edge outside reset.
`define BC15_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error(msg);

`endif

// ----- rtl/bc15_pkg.sv -----
// Shared types, format codes and arithmetic helpers for the BC1 to BC5 decoder.
// No dependencies; used by the interfaces, the palette pipeline and the top level.
package bc15_pkg;

  localparam int FmtW = 3;

  localparam logic [FmtW-1:0] FMT_BC1 = 3'd0;
  localparam logic [FmtW-1:0] FMT_BC2 = 3'd1;
  localparam logic [FmtW-1:0] FMT_BC3 = 3'd2;
  localparam logic [FmtW-1:0] FMT_BC4 = 3'd3;
  localparam logic [FmtW-1:0] FMT_BC5 = 3'd4;

  localparam logic [3:0] LAST_TEXEL = 4'd15;

  typedef logic [7:0] chan_t;
  typedef chan_t [31:0] exp5_tbl_t;
  typedef chan_t [63:0] exp6_tbl_t;

  localparam chan_t CHAN_MAX = 8'd255;

  // Palettes and raw index words of one block, handed to the serializer.
  typedef struct packed {
    logic [FmtW-1:0]  fmt;
    logic [63:0]      lo;
    logic [63:0]      hi;
    chan_t [3:0][2:0] cpal;   // [entry][R,G,B]
    chan_t            alpha3; // alpha of colour entry 3 in BC1
    chan_t [7:0]      spal0;
    chan_t [7:0]      spal1;
  } pal_t;

  function automatic exp5_tbl_t gen_exp5();
    exp5_tbl_t t;
    for (int i = 0; i < 32; i++) begin
      t[i] = chan_t'((i * 255) / 31);
    end
    return t;
  endfunction

  function automatic exp6_tbl_t gen_exp6();
    exp6_tbl_t t;
    for (int i = 0; i < 64; i++) begin
      t[i] = chan_t'((i * 255) / 63);
    end
    return t;
  endfunction

  localparam exp5_tbl_t EXP5 = gen_exp5();
  localparam exp6_tbl_t EXP6 = gen_exp6();

  // Truncating division by 3 for x below 2048, by reciprocal 683/2048.
  function automatic chan_t div3(input logic [9:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'd683;
    return p[18:11];
  endfunction

  // Truncating division by 5 for x below 16384, by reciprocal 3277/16384.
  function automatic chan_t div5(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd3277;
    return p[21:14];
  endfunction

  // Truncating division by 7 for x below 5461, by reciprocal 2341/16384.
  function automatic chan_t div7(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd2341;
    return p[21:14];
  endfunction

endpackage

// ----- rtl/bc15_if.sv -----
// Handshake channel interfaces: compressed block input, texel output, format writes.
// Depends on bc15_pkg for the format width and channel type.
interface bc15_blk_if import bc15_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [63:0] block_low;
  logic [63:0] block_high;

  modport source (output valid, block_low, block_high, input ready);
  modport sink   (input valid, block_low, block_high, output ready);
endinterface

interface bc15_texel_if import bc15_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] texel_x;
  logic [1:0] texel_y;
  chan_t      red;
  chan_t      green;
  chan_t      blue;
  chan_t      alpha;
  logic       last_texel;

  modport source (output valid, texel_x, texel_y, red, green, blue, alpha, last_texel,
                  input ready);
  modport sink   (input valid, texel_x, texel_y, red, green, blue, alpha, last_texel,
                  output ready);
endinterface

interface bc15_cfg_if import bc15_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [FmtW-1:0] format_select;

  modport source (output valid, format_select, input ready);
  modport sink   (input valid, format_select, output ready);
endinterface

// ----- rtl/bc1_to_bc5_block_decoder.sv -----
// Path: an accepted block passes palette stages A, B and C, the serializer and the output
// register in order; further blocks follow with no gap.
// Throughput: one texel per cycle on the texel channel while texel_o.ready is high; the
// palette pipeline buffers up to three more blocks behind the texel serializer.
// Reset: rst_ni clears all valid bits, the texel counter and format_select (BC1).
// Depends on bc15_pkg, the bc15 interfaces and bc15_pal.
module bc1_to_bc5_block_decoder import bc15_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  bc15_blk_if.sink    blk_i,
  bc15_cfg_if.sink    cfg_i,
  bc15_texel_if.source texel_o
);

  logic [FmtW-1:0] fmt_q;

  logic pal_valid, pal_ready;
  pal_t pal;

  logic       ser_valid_q;
  logic [3:0] ser_cnt_q;
  pal_t       ser_pal_q;
  logic       ser_mv, ser_done;

  logic        out_valid_q;
  logic [3:0]  out_pos_q;
  chan_t       out_r_q, out_g_q, out_b_q, out_a_q;
  chan_t       tex_r, tex_g, tex_b, tex_a;
  logic [31:0] cidx_word;
  logic [1:0]  ci;
  logic [5:0]  sidx_pos;
  logic [47:0] sidx0_word, sidx1_word;
  logic [2:0]  si0, si1;
  logic [3:0]  alpha4;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_BC1;
    end else if (cfg_i.valid) begin
      fmt_q <= cfg_i.format_select;
    end
  end

  bc15_pal u_pal (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (blk_i.valid),
    .in_ready_o  (blk_i.ready),
    .fmt_i       (fmt_q),
    .lo_i        (blk_i.block_low),
    .hi_i        (blk_i.block_high),
    .out_valid_o (pal_valid),
    .out_ready_i (pal_ready),
    .out_o       (pal)
  );

  // The serializer steps through the sixteen texels whenever the output register frees up.
  assign ser_mv    = ser_valid_q && (!out_valid_q || texel_o.ready);
  assign ser_done  = ser_mv && (ser_cnt_q == LAST_TEXEL);
  assign pal_ready = !ser_valid_q || ser_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_valid_q <= 1'b0;
      ser_cnt_q   <= 4'd0;
    end else begin
      if (pal_ready) begin
        ser_valid_q <= pal_valid;
        ser_cnt_q   <= 4'd0;
      end else if (ser_mv) begin
        ser_cnt_q <= ser_cnt_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pal_ready && pal_valid) begin
      ser_pal_q <= pal;
    end
  end

  // Index extraction for the current texel.
  assign cidx_word  = (ser_pal_q.fmt == FMT_BC1) ? ser_pal_q.lo[63:32] : ser_pal_q.hi[63:32];
  assign ci         = cidx_word[{ser_cnt_q, 1'b0} +: 2];
  assign sidx_pos   = {2'b00, ser_cnt_q} + {1'b0, ser_cnt_q, 1'b0};
  assign sidx0_word = ser_pal_q.lo[63:16];
  assign sidx1_word = ser_pal_q.hi[63:16];
  assign si0        = sidx0_word[sidx_pos +: 3];
  assign si1        = sidx1_word[sidx_pos +: 3];
  assign alpha4     = ser_pal_q.lo[{ser_cnt_q, 2'b00} +: 4];

  always_comb begin
    tex_r = 8'd0;
    tex_g = 8'd0;
    tex_b = 8'd0;
    tex_a = CHAN_MAX;
    case (ser_pal_q.fmt)
      FMT_BC1: begin
        tex_r = ser_pal_q.cpal[ci][0];
        tex_g = ser_pal_q.cpal[ci][1];
        tex_b = ser_pal_q.cpal[ci][2];
        tex_a = (ci == 2'd3) ? ser_pal_q.alpha3 : CHAN_MAX;
      end
      FMT_BC2: begin
        tex_r = ser_pal_q.cpal[ci][0];
        tex_g = ser_pal_q.cpal[ci][1];
        tex_b = ser_pal_q.cpal[ci][2];
        // Four-bit alpha times 17 is the nibble repeated.
        tex_a = {alpha4, alpha4};
      end
      FMT_BC3: begin
        tex_r = ser_pal_q.cpal[ci][0];
        tex_g = ser_pal_q.cpal[ci][1];
        tex_b = ser_pal_q.cpal[ci][2];
        tex_a = ser_pal_q.spal0[si0];
      end
      FMT_BC4: begin
        tex_r = ser_pal_q.spal0[si0];
      end
      FMT_BC5: begin
        tex_r = ser_pal_q.spal0[si0];
        tex_g = ser_pal_q.spal1[si1];
      end
      default: begin
        tex_a = CHAN_MAX;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ser_mv) begin
      out_valid_q <= 1'b1;
    end else if (texel_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_mv) begin
      out_pos_q <= ser_cnt_q;
      out_r_q   <= tex_r;
      out_g_q   <= tex_g;
      out_b_q   <= tex_b;
      out_a_q   <= tex_a;
    end
  end

  assign texel_o.valid      = out_valid_q;
  assign texel_o.texel_x    = out_pos_q[1:0];
  assign texel_o.texel_y    = out_pos_q[3:2];
  assign texel_o.red        = out_r_q;
  assign texel_o.green      = out_g_q;
  assign texel_o.blue       = out_b_q;
  assign texel_o.alpha      = out_a_q;
  assign texel_o.last_texel = (out_pos_q == LAST_TEXEL);

endmodule

// ----- rtl/bc15_pal.sv -----
// Three-stage palette pipeline: endpoint expansion, weighted sums, reciprocal division.
// Depends on bc15_pkg for pal_t, the expansion tables and the division helpers.
module bc15_pal import bc15_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [FmtW-1:0] fmt_i,
  input  logic [63:0]     lo_i,
  input  logic [63:0]     hi_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pal_t            out_o
);

  logic a_valid_q, b_valid_q, c_valid_q;
  logic a_ready, b_ready, c_ready;

  // Stage A
  logic [FmtW-1:0] a_fmt_q;
  logic [63:0]     a_lo_q, a_hi_q;
  chan_t [2:0]     a_ca_q, a_cb_q, a_ca_d, a_cb_d;
  logic            a_four_q, a_four_d;
  logic [31:0]     cword;

  // Stage B
  logic [FmtW-1:0]        b_fmt_q;
  logic [63:0]            b_lo_q, b_hi_q;
  chan_t [2:0]            b_ca_q, b_cb_q;
  logic                   b_four_q;
  logic [2:0][9:0]        b_s2ab_q, b_sa2b_q, b_s2ab_d, b_sa2b_d;
  logic [2:0][8:0]        b_sab_q, b_sab_d;
  logic [1:0][5:0][10:0]  b_w7_q, b_w7_d;
  logic [1:0][3:0][10:0]  b_w5_q, b_w5_d;
  logic [1:0]             b_gt_q, b_gt_d;
  chan_t [1:0]            e0, e1;

  // Stage C
  pal_t c_pal_q, c_pal_d;

  assign c_ready    = !c_valid_q || out_ready_i;
  assign b_ready    = !b_valid_q || c_ready;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= in_valid_i;
      if (b_ready) b_valid_q <= a_valid_q;
      if (c_ready) c_valid_q <= b_valid_q;
    end
  end

  // Stage A: pick the colour half and expand both R5G6B5 endpoints.
  assign cword = (fmt_i == FMT_BC1) ? lo_i[31:0] : hi_i[31:0];

  always_comb begin
    a_ca_d[0] = EXP5[cword[15:11]];
    a_ca_d[1] = EXP6[cword[10:5]];
    a_ca_d[2] = EXP5[cword[4:0]];
    a_cb_d[0] = EXP5[cword[31:27]];
    a_cb_d[1] = EXP6[cword[26:21]];
    a_cb_d[2] = EXP5[cword[20:16]];
    // Only BC1 may fall back to the three-colour mode.
    a_four_d  = (fmt_i != FMT_BC1) || (cword[15:0] > cword[31:16]);
  end

  always_ff @(posedge clk_i) begin
    if (a_ready) begin
      a_fmt_q  <= fmt_i;
      a_lo_q   <= lo_i;
      a_hi_q   <= hi_i;
      a_ca_q   <= a_ca_d;
      a_cb_q   <= a_cb_d;
      a_four_q <= a_four_d;
    end
  end

  // Stage B: weighted endpoint sums for both palette kinds.
  assign e0[0] = a_lo_q[7:0];
  assign e1[0] = a_lo_q[15:8];
  assign e0[1] = a_hi_q[7:0];
  assign e1[1] = a_hi_q[15:8];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      b_s2ab_d[ch] = {1'b0, a_ca_q[ch], 1'b0} + {2'b00, a_cb_q[ch]};
      b_sa2b_d[ch] = {2'b00, a_ca_q[ch]} + {1'b0, a_cb_q[ch], 1'b0};
      b_sab_d[ch]  = {1'b0, a_ca_q[ch]} + {1'b0, a_cb_q[ch]};
    end
    for (int s = 0; s < 2; s++) begin
      b_gt_d[s] = e0[s] > e1[s];
      for (int j = 0; j < 6; j++) begin
        b_w7_d[s][j] = 11'(e0[s]) * 11'(6 - j) + 11'(e1[s]) * 11'(j + 1);
      end
      for (int j = 0; j < 4; j++) begin
        b_w5_d[s][j] = 11'(e0[s]) * 11'(4 - j) + 11'(e1[s]) * 11'(j + 1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready) begin
      b_fmt_q  <= a_fmt_q;
      b_lo_q   <= a_lo_q;
      b_hi_q   <= a_hi_q;
      b_ca_q   <= a_ca_q;
      b_cb_q   <= a_cb_q;
      b_four_q <= a_four_q;
      b_s2ab_q <= b_s2ab_d;
      b_sa2b_q <= b_sa2b_d;
      b_sab_q  <= b_sab_d;
      b_w7_q   <= b_w7_d;
      b_w5_q   <= b_w5_d;
      b_gt_q   <= b_gt_d;
    end
  end

  // Stage C: divide the sums and assemble the palettes.
  always_comb begin
    c_pal_d.fmt    = b_fmt_q;
    c_pal_d.lo     = b_lo_q;
    c_pal_d.hi     = b_hi_q;
    c_pal_d.alpha3 = b_four_q ? CHAN_MAX : 8'd0;
    for (int ch = 0; ch < 3; ch++) begin
      c_pal_d.cpal[0][ch] = b_ca_q[ch];
      c_pal_d.cpal[1][ch] = b_cb_q[ch];
      if (b_four_q) begin
        c_pal_d.cpal[2][ch] = div3(b_s2ab_q[ch]);
        c_pal_d.cpal[3][ch] = div3(b_sa2b_q[ch]);
      end else begin
        c_pal_d.cpal[2][ch] = b_sab_q[ch][8:1];
        c_pal_d.cpal[3][ch] = 8'd0;
      end
    end
    c_pal_d.spal0[0] = b_lo_q[7:0];
    c_pal_d.spal0[1] = b_lo_q[15:8];
    c_pal_d.spal1[0] = b_hi_q[7:0];
    c_pal_d.spal1[1] = b_hi_q[15:8];
    for (int j = 0; j < 6; j++) begin
      if (b_gt_q[0]) begin
        c_pal_d.spal0[j+2] = div7(b_w7_q[0][j]);
      end else if (j < 4) begin
        c_pal_d.spal0[j+2] = div5(b_w5_q[0][j]);
      end else begin
        c_pal_d.spal0[j+2] = (j == 4) ? 8'd0 : CHAN_MAX;
      end
      if (b_gt_q[1]) begin
        c_pal_d.spal1[j+2] = div7(b_w7_q[1][j]);
      end else if (j < 4) begin
        c_pal_d.spal1[j+2] = div5(b_w5_q[1][j]);
      end else begin
        c_pal_d.spal1[j+2] = (j == 4) ? 8'd0 : CHAN_MAX;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready) begin
      c_pal_q <= c_pal_d;
    end
  end

  assign out_valid_o = c_valid_q;
  assign out_o       = c_pal_q;

endmodule

// ----- rtl/bc15_chk.sv -----
// Port-level checker for the BC1 to BC5 block decoder, bound to the top level.
// Depends on bc1_to_bc5_block_decoder_macros.svh for the assertion macros.
`include "bc1_to_bc5_block_decoder_macros.svh"

module bc15_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] texel_x_i,
  input logic [1:0] texel_y_i,
  input logic       last_texel_i
);

  logic       in_acc, out_acc;
  logic [3:0] exp_pos_q;
  logic [3:0] owed_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Expected texel position and number of blocks whose texels are not all delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_pos_q <= 4'd0;
      owed_q    <= 4'd0;
    end else begin
      if (out_acc) exp_pos_q <= exp_pos_q + 4'd1;
      owed_q <= owed_q + {3'd0, in_acc} - {3'd0, out_acc && last_texel_i};
    end
  end

  `BC15_ASSERT_IMP(a_texel_order, out_acc, ({texel_y_i, texel_x_i} == exp_pos_q), "texel out of row order")
  `BC15_ASSERT_IMP(a_last_mark, out_valid_i, (last_texel_i == (texel_x_i == 2'd3 && texel_y_i == 2'd3)), "last_texel mark on wrong texel")
  `BC15_ASSERT_IMP(a_no_orphan, out_valid_i, (owed_q != 4'd0), "texel shown with no block outstanding")
  `BC15_ASSERT_IMP(a_out_hold, out_valid_i && !out_ready_i, ##1 (out_valid_i && $stable(texel_x_i) && $stable(texel_y_i)), "stalled texel request dropped or changed")

endmodule

bind bc1_to_bc5_block_decoder bc15_chk u_bc15_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (blk_i.valid),
  .in_ready_i   (blk_i.ready),
  .out_valid_i  (texel_o.valid),
  .out_ready_i  (texel_o.ready),
  .texel_x_i    (texel_o.texel_x),
  .texel_y_i    (texel_o.texel_y),
  .last_texel_i (texel_o.last_texel)
);
